// ----- rtl/hsvg_pkg.sv -----
// shared types and constants for the hsv to grb pixel converter
package hsvg_pkg;

    localparam int HUE_W = 9;
    localparam int CHAN_W = 8;
    localparam int GRB_W = 3 * CHAN_W;
    localparam int ANGLE_W = 6;
    localparam int PROD_W = 2 * CHAN_W;
    localparam int NUM_W = 22;

    typedef logic [HUE_W-1:0]   hue_t;
    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [GRB_W-1:0]   grb_t;
    typedef logic [ANGLE_W-1:0] angle_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [NUM_W-1:0]   num_t;

    localparam int HUE_FULL = 360;
    localparam int HSV_SCALE = 255;
    localparam int HSV_SECTOR = 60;
    localparam int MID_DEN = HSV_SCALE * HSV_SECTOR;

    // reciprocal of the scale, with a 16-bit shift, for the 8-bit low channel estimate
    localparam int LOW_RECIP = 257;
    localparam int LOW_SHIFT = 16;

    // reciprocal of 15300 for the x channel estimate, never above the exact quotient
    localparam int MID_SHIFT = 32;
    localparam logic [31:0] MID_RECIP = 32'((64'd1 << MID_SHIFT) / MID_DEN);

    typedef enum logic [2:0] {
        SECTOR_RED_YEL,
        SECTOR_YEL_GRN,
        SECTOR_GRN_CYN,
        SECTOR_CYN_BLU,
        SECTOR_BLU_MAG,
        SECTOR_MAG_RED
    } sector_t;

endpackage

// ----- rtl/hsv_pixel_if.sv -----
// valid/ready channel carrying one hsv pixel
interface hsv_pixel_if import hsvg_pkg::*; ();
    logic  valid;
    logic  ready;
    hue_t  hue;
    chan_t saturation;
    chan_t brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

// ----- rtl/grb_pixel_if.sv -----
// valid/ready channel carrying one converted grb pixel
interface grb_pixel_if import hsvg_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;
    grb_t  grb_word;

    modport source (output valid, red, green, blue, grb_word, input ready);
    modport sink (input valid, red, green, blue, grb_word, output ready);
endinterface

// ----- rtl/hsv_to_grb_pixel.sv -----
// hsv to grb pixel converter, four-stage pipeline
//
// usage:
//   pix_in carries one hsv pixel per transaction: hue in whole degrees
//   (codes 360..511 wrap once by 360), saturation and brightness as 8-bit
//   fractions of 255. pix_out carries red, green, blue and the packed
//   grb word (green 23:16, red 15:8, blue 7:0), one per input transaction.
// throughput: one pixel per cycle; a new transaction is taken every cycle
//   while the output side keeps up.
// pipeline stages, in order from input transaction to output valid:
//   stage 1: hue wrap, sector pick, hue distance, v*s and v*(255-s)
//   stage 2: x channel numerator, low channel reciprocal estimate
//   stage 3: x channel reciprocal estimate, low channel correction
//   stage 4: x channel correction and channel routing (output register)
// reset: all stage valid bits clear, the pipe is empty, pix_in.ready high.
// stall: each stage holds while the one after it is full and stalled, so a
//   stall on pix_out backs up one stage at a time; when all four stages
//   are full pix_in.ready drops. no transaction is lost or repeated.
module hsv_to_grb_pixel import hsvg_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    hsv_pixel_if.sink    pix_in,
    grb_pixel_if.source  pix_out
);

    // per-stage valid bits and stage advance enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    // stage 1 registers
    sector_t s1_sector_reg, s1_sector_next;
    angle_t  s1_dist_reg, s1_dist_next;
    prod_t   s1_vs_reg, s1_vs_next;
    prod_t   s1_vns_reg, s1_vns_next;
    chan_t   s1_top_reg;

    // stage 2 registers
    sector_t s2_sector_reg;
    num_t    s2_num_reg, s2_num_next;
    prod_t   s2_vns_reg;
    chan_t   s2_low_est_reg, s2_low_est_next;
    chan_t   s2_top_reg;

    // stage 3 registers
    sector_t s3_sector_reg;
    num_t    s3_num_reg;
    chan_t   s3_mid_est_reg, s3_mid_est_next;
    chan_t   s3_low_reg, s3_low_next;
    chan_t   s3_top_reg;

    // stage 4 output registers
    chan_t   s4_red_reg, s4_red_next;
    chan_t   s4_green_reg, s4_green_next;
    chan_t   s4_blue_reg, s4_blue_next;

    // a stage advances when it is empty or its successor advances
    assign s4_ready = !s4_valid_reg || pix_out.ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign pix_in.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pix_in.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // stage 1: wrap hue, find the 60-degree sector and distance from the nearest odd multiple of 60 degrees
    always_comb
    begin
        hue_t hue_w;
        hue_w = pix_in.hue;
        if (pix_in.hue >= hue_t'(HUE_FULL))
        begin
            hue_w = pix_in.hue - hue_t'(HUE_FULL);
        end

        // d = |hue mod 120 - 60|
        if (hue_w < hue_t'(HSV_SECTOR))
        begin
            s1_sector_next = SECTOR_RED_YEL;
            s1_dist_next   = angle_t'(hue_t'(HSV_SECTOR) - hue_w);
        end
        else if (hue_w < hue_t'(2 * HSV_SECTOR))
        begin
            s1_sector_next = SECTOR_YEL_GRN;
            s1_dist_next   = angle_t'(hue_w - hue_t'(HSV_SECTOR));
        end
        else if (hue_w < hue_t'(3 * HSV_SECTOR))
        begin
            s1_sector_next = SECTOR_GRN_CYN;
            s1_dist_next   = angle_t'(hue_t'(3 * HSV_SECTOR) - hue_w);
        end
        else if (hue_w < hue_t'(4 * HSV_SECTOR))
        begin
            s1_sector_next = SECTOR_CYN_BLU;
            s1_dist_next   = angle_t'(hue_w - hue_t'(3 * HSV_SECTOR));
        end
        else if (hue_w < hue_t'(5 * HSV_SECTOR))
        begin
            s1_sector_next = SECTOR_BLU_MAG;
            s1_dist_next   = angle_t'(hue_t'(5 * HSV_SECTOR) - hue_w);
        end
        else
        begin
            s1_sector_next = SECTOR_MAG_RED;
            s1_dist_next   = angle_t'(hue_w - hue_t'(5 * HSV_SECTOR));
        end

        // chroma product and the grey part v*(255-s)
        s1_vs_next  = prod_t'(pix_in.brightness) * prod_t'(pix_in.saturation);
        s1_vns_next = prod_t'(pix_in.brightness)
                    * prod_t'(chan_t'(HSV_SCALE) - pix_in.saturation);
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_sector_reg <= s1_sector_next;
            s1_dist_reg   <= s1_dist_next;
            s1_vs_reg     <= s1_vs_next;
            s1_vns_reg    <= s1_vns_next;
            s1_top_reg    <= pix_in.brightness;
        end
    end

    // stage 2: x numerator v*s*(60-d) + 60*v*(255-s), below 2^22
    always_comb
    begin
        logic [23:0] low_scaled;
        s2_num_next = num_t'(s1_vs_reg) * num_t'(angle_t'(HSV_SECTOR) - s1_dist_reg)
                    + num_t'(s1_vns_reg) * num_t'(HSV_SECTOR);
        // floor(vns*257/65536) is the quotient by 255 or one below it
        low_scaled      = 24'(s1_vns_reg) * 24'(LOW_RECIP);
        s2_low_est_next = chan_t'(low_scaled >> LOW_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_sector_reg  <= s1_sector_reg;
            s2_num_reg     <= s2_num_next;
            s2_vns_reg     <= s1_vns_reg;
            s2_low_est_reg <= s2_low_est_next;
            s2_top_reg     <= s1_top_reg;
        end
    end

    // stage 3: x quotient estimate, low channel remainder correction
    always_comb
    begin
        logic [53:0] mid_scaled;
        prod_t       low_rem;
        mid_scaled      = 54'(s2_num_reg) * 54'(MID_RECIP);
        s3_mid_est_next = mid_scaled[MID_SHIFT +: CHAN_W];

        low_rem = s2_vns_reg - prod_t'(s2_low_est_reg) * prod_t'(HSV_SCALE);
        s3_low_next = s2_low_est_reg;
        if (low_rem >= prod_t'(HSV_SCALE))
        begin
            s3_low_next = s2_low_est_reg + chan_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_sector_reg  <= s2_sector_reg;
            s3_num_reg     <= s2_num_reg;
            s3_mid_est_reg <= s3_mid_est_next;
            s3_low_reg     <= s3_low_next;
            s3_top_reg     <= s2_top_reg;
        end
    end

    // stage 4: x quotient correction and routing of max / x / low by sector
    always_comb
    begin
        num_t  mid_rem;
        chan_t mid;
        mid_rem = s3_num_reg - num_t'(s3_mid_est_reg) * num_t'(MID_DEN);
        mid = s3_mid_est_reg;
        if (mid_rem >= num_t'(MID_DEN))
        begin
            mid = s3_mid_est_reg + chan_t'(1);
        end

        case (s3_sector_reg)
            SECTOR_RED_YEL:
            begin
                s4_red_next   = s3_top_reg;
                s4_green_next = mid;
                s4_blue_next  = s3_low_reg;
            end
            SECTOR_YEL_GRN:
            begin
                s4_red_next   = mid;
                s4_green_next = s3_top_reg;
                s4_blue_next  = s3_low_reg;
            end
            SECTOR_GRN_CYN:
            begin
                s4_red_next   = s3_low_reg;
                s4_green_next = s3_top_reg;
                s4_blue_next  = mid;
            end
            SECTOR_CYN_BLU:
            begin
                s4_red_next   = s3_low_reg;
                s4_green_next = mid;
                s4_blue_next  = s3_top_reg;
            end
            SECTOR_BLU_MAG:
            begin
                s4_red_next   = mid;
                s4_green_next = s3_low_reg;
                s4_blue_next  = s3_top_reg;
            end
            default:
            begin
                s4_red_next   = s3_top_reg;
                s4_green_next = s3_low_reg;
                s4_blue_next  = mid;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            s4_red_reg   <= s4_red_next;
            s4_green_reg <= s4_green_next;
            s4_blue_reg  <= s4_blue_next;
        end
    end

    assign pix_out.valid    = s4_valid_reg;
    assign pix_out.red      = s4_red_reg;
    assign pix_out.green    = s4_green_reg;
    assign pix_out.blue     = s4_blue_reg;
    assign pix_out.grb_word = {s4_green_reg, s4_red_reg, s4_blue_reg};

endmodule
